[hw/rtl/ctkd_pkg.sv]
`default_nettype none
package ctkd_pkg;

   localparam int SAMPLE_W          = 16;
   localparam int GATE_W            = 8;
   localparam int CNT_W             = 3;
   localparam int HOLD_W            = 2;
   localparam int SCAN_SAMPLES_DEF  = 3;
   localparam int CONT_SAMPLES_DEF  = 6;

   localparam int CAL_DEPTH    = 10;
   localparam int CAL_IDX_W    = $clog2(CAL_DEPTH);
   localparam int MID_FIRST    = 2;
   localparam int MID_COUNT    = 6;
   localparam int HOLDOFF_LOAD = 3;
   localparam int RANGE_FACTOR = 10;
   localparam int GATE_RESET   = 100;

   localparam int SUM_W   = SAMPLE_W + $clog2(MID_COUNT);
   localparam int RANGE_W = SAMPLE_W + $clog2(RANGE_FACTOR);
   localparam int STEP_W  = $clog2(CAL_DEPTH);

   // reciprocal of six, exact for any sum of SUM_W bits
   localparam int DIV_SHIFT = SUM_W + 3;
   localparam int DIV_RECIP = (2 ** DIV_SHIFT + MID_COUNT - 1) / MID_COUNT;
   localparam int RECIP_W   = $clog2(DIV_RECIP + 1);
   localparam int PROD_W    = SUM_W + RECIP_W;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic REG_GATE       = 1'b0;
   localparam logic REG_CONTINUOUS = 1'b1;

   localparam logic KIND_CAL  = 1'b0;
   localparam logic KIND_SCAN = 1'b1;

   localparam logic MODE_CAL  = 1'b0;
   localparam logic MODE_SCAN = 1'b1;

   typedef struct packed {
      logic                 in_ready;
      logic                 cal_write;
      logic                 scan_update;
      logic                 sort_en;
      logic                 sort_odd;
      logic                 sum_clear;
      logic                 sum_en;
      logic [CAL_IDX_W-1:0] sum_idx;
      logic                 div_en;
      logic                 cal_finish;
      logic                 scan_finish;
      logic                 load_out;
   } ctkd_cmd_type;

   typedef struct packed {
      logic cal_last;
      logic scan_last;
   } ctkd_stat_type;

   typedef struct packed {
      logic                result_kind;
      logic                touched;
      logic [SAMPLE_W-1:0] peak;
      logic [SAMPLE_W-1:0] baseline;
   } ctkd_result_type;

endpackage
`default_nettype wire

[hw/rtl/ctkd_req_if.sv]
`default_nettype none
interface ctkd_req_if;
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic [ctkd_pkg::SAMPLE_W-1:0] charge_time;

   modport source (output valid, output mode, output charge_time, input ready);
   modport sink   (input valid, input mode, input charge_time, output ready);
endinterface
`default_nettype wire

[hw/rtl/ctkd_rsp_if.sv]
`default_nettype none
interface ctkd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          result_kind;
   logic                          touched;
   logic [ctkd_pkg::SAMPLE_W-1:0] peak;
   logic [ctkd_pkg::SAMPLE_W-1:0] baseline;

   modport source (output valid, output result_kind, output touched, output peak,
                   output baseline, input ready);
   modport sink   (input valid, input result_kind, input touched, input peak,
                   input baseline, output ready);
endinterface
`default_nettype wire

[hw/rtl/ctkd_ctrl.sv]
`default_nettype none
module ctkd_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_fire,
   input  wire logic                    in_mode,
   input  wire logic                    out_free,
   input  wire ctkd_pkg::ctkd_stat_type stat,
   output      ctkd_pkg::ctkd_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SORT    = 3'd1;
   localparam logic [2:0] S_SUM     = 3'd2;
   localparam logic [2:0] S_DIV     = 3'd3;
   localparam logic [2:0] S_CALFIN  = 3'd4;
   localparam logic [2:0] S_SCANFIN = 3'd5;

   localparam int STEP_W = ctkd_pkg::STEP_W;

   logic [2:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      step_in  = step_ff;
      cmd.sort_odd = step_ff[0];
      cmd.sum_idx  = ctkd_pkg::CAL_IDX_W'(ctkd_pkg::MID_FIRST)
                     + step_ff[ctkd_pkg::CAL_IDX_W-1:0];
      unique case (state_ff)
         S_IDLE: begin
            cmd.in_ready = 1'b1;
            step_in      = '0;
            if (in_fire) begin
               if (in_mode == ctkd_pkg::MODE_CAL) begin
                  cmd.cal_write = 1'b1;
                  if (stat.cal_last) begin
                     cmd.sum_clear = 1'b1;
                     state_in      = S_SORT;
                  end
               end else begin
                  cmd.scan_update = 1'b1;
                  if (stat.scan_last) begin
                     state_in = S_SCANFIN;
                  end
               end
            end
         end
         S_SORT: begin
            cmd.sort_en = 1'b1;
            if (step_ff == STEP_W'(ctkd_pkg::CAL_DEPTH - 1)) begin
               step_in  = '0;
               state_in = S_SUM;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_SUM: begin
            cmd.sum_en = 1'b1;
            if (step_ff == STEP_W'(ctkd_pkg::MID_COUNT - 1)) begin
               step_in  = '0;
               state_in = S_DIV;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_en = 1'b1;
            state_in   = S_CALFIN;
         end
         S_CALFIN: begin
            if (out_free) begin
               cmd.cal_finish = 1'b1;
               cmd.load_out   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_SCANFIN: begin
            if (out_free) begin
               cmd.scan_finish = 1'b1;
               cmd.load_out    = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/ctkd_datapath.sv]
`default_nettype none
module ctkd_datapath #(
   parameter int SCAN_SAMPLES      = ctkd_pkg::SCAN_SAMPLES_DEF,
   parameter int CONT_SCAN_SAMPLES = ctkd_pkg::CONT_SAMPLES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire ctkd_pkg::ctkd_cmd_type          cmd,
   input  wire logic [ctkd_pkg::SAMPLE_W-1:0]   sample,
   input  wire logic [ctkd_pkg::GATE_W-1:0]     gate,
   input  wire logic                            continuous,
   output      ctkd_pkg::ctkd_stat_type         stat,
   output      ctkd_pkg::ctkd_result_type       result
);

   localparam int SW      = ctkd_pkg::SAMPLE_W;
   localparam int DEPTH   = ctkd_pkg::CAL_DEPTH;
   localparam int IDX_W   = ctkd_pkg::CAL_IDX_W;
   localparam int SUM_W   = ctkd_pkg::SUM_W;
   localparam int PROD_W  = ctkd_pkg::PROD_W;
   localparam int CNT_W   = ctkd_pkg::CNT_W;
   localparam int HOLD_W  = ctkd_pkg::HOLD_W;
   localparam int RANGE_W = ctkd_pkg::RANGE_W;

   logic [SW-1:0]     store_ff [DEPTH];
   logic [SW-1:0]     store_in [DEPTH];
   logic [IDX_W-1:0]  cal_cnt_ff, cal_cnt_in;
   logic [CNT_W-1:0]  scan_cnt_ff, scan_cnt_in;
   logic [SW-1:0]     peak_ff, peak_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;
   logic [SW-1:0]     base_ff, base_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SW-1:0]     quo_ff, quo_in;

   logic [CNT_W-1:0]   scan_next;
   logic [CNT_W-1:0]   need;
   logic [SUM_W-1:0]   sum_next;
   logic [PROD_W-1:0]  div_prod;
   logic [SW:0]        low_bound;
   logic [RANGE_W-1:0] high_bound;
   logic               in_range;
   logic [HOLD_W-1:0]  hold_eff;
   logic               touch;

   // sample store and odd-even transposition sort
   always_comb begin
      store_in = store_ff;
      if (cmd.cal_write) begin
         store_in[cal_cnt_ff] = sample;
      end else if (cmd.sort_en) begin
         for (int k = 0; k < DEPTH - 1; k++) begin
            if (((k % 2) == int'(cmd.sort_odd)) && (store_ff[k] > store_ff[k+1])) begin
               store_in[k]   = store_ff[k+1];
               store_in[k+1] = store_ff[k];
            end
         end
      end
   end

   assign stat.cal_last = (cal_cnt_ff == IDX_W'(DEPTH - 1));

   always_comb begin
      cal_cnt_in = cal_cnt_ff;
      if (cmd.cal_write) begin
         cal_cnt_in = stat.cal_last ? '0 : cal_cnt_ff + 1'b1;
      end
   end

   // middle sum, then divide by six through a reciprocal multiply
   assign sum_next = sum_ff + SUM_W'(store_ff[cmd.sum_idx]);
   assign div_prod = PROD_W'(sum_ff) * PROD_W'(ctkd_pkg::DIV_RECIP);

   always_comb begin
      sum_in = sum_ff;
      quo_in = quo_ff;
      if (cmd.sum_clear) begin
         sum_in = '0;
      end else if (cmd.sum_en) begin
         sum_in = sum_next;
      end
      if (cmd.div_en) begin
         quo_in = div_prod[ctkd_pkg::DIV_SHIFT +: SW];
      end
   end

   // scan grouping and touch decision
   assign scan_next      = scan_cnt_ff + 1'b1;
   assign need           = continuous ? CNT_W'(CONT_SCAN_SAMPLES) : CNT_W'(SCAN_SAMPLES);
   assign stat.scan_last = (scan_next >= need) || (scan_next == '0);

   assign low_bound  = (SW+1)'(base_ff) + (SW+1)'(gate);
   assign high_bound = RANGE_W'(base_ff) * RANGE_W'(ctkd_pkg::RANGE_FACTOR);
   assign in_range   = ((SW+1)'(peak_ff) > low_bound) && (RANGE_W'(peak_ff) < high_bound);
   assign hold_eff   = continuous ? '0 : hold_ff;
   assign touch      = in_range && (hold_eff == '0);

   always_comb begin
      scan_cnt_in = scan_cnt_ff;
      peak_in     = peak_ff;
      hold_in     = hold_ff;
      base_in     = base_ff;
      if (cmd.scan_update) begin
         scan_cnt_in = scan_next;
         if (sample > peak_ff) begin
            peak_in = sample;
         end
      end
      if (cmd.scan_finish) begin
         scan_cnt_in = '0;
         peak_in     = '0;
         if (in_range) begin
            hold_in = HOLD_W'(ctkd_pkg::HOLDOFF_LOAD - 1);
         end else if (hold_eff != '0) begin
            hold_in = hold_eff - 1'b1;
         end else begin
            hold_in = '0;
         end
      end
      if (cmd.cal_finish) begin
         base_in = quo_ff;
      end
   end

   always_comb begin
      if (cmd.cal_finish) begin
         result.result_kind = ctkd_pkg::KIND_CAL;
         result.touched     = 1'b0;
         result.peak        = '0;
         result.baseline    = quo_ff;
      end else begin
         result.result_kind = ctkd_pkg::KIND_SCAN;
         result.touched     = touch;
         result.peak        = peak_ff;
         result.baseline    = base_ff;
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
      sum_ff   <= sum_in;
      quo_ff   <= quo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_cnt_ff  <= '0;
         scan_cnt_ff <= '0;
         peak_ff     <= '0;
         hold_ff     <= '0;
         base_ff     <= '0;
      end else begin
         cal_cnt_ff  <= cal_cnt_in;
         scan_cnt_ff <= scan_cnt_in;
         peak_ff     <= peak_in;
         hold_ff     <= hold_in;
         base_ff     <= base_in;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/capacitive_touch_key_detector.sv]
// Capacitive touch key detector, charge-time method.
// req_bus carries one measured charge time per item, tagged calibration or scan.
// rsp_bus carries one result item when a calibration pass or a scan closes.
// Ten calibration items produce a baseline result; a scan closes after
// SCAN_SAMPLES items, or CONT_SCAN_SAMPLES with continuous set.
// An item that closes nothing leaves the block ready for the next item.
// A closing scan item gives its result once the output register is free.
// The tenth calibration item starts a sequence of 10 sort phases, a sum of the
// six middle sorted values and one reciprocal multiply for the divide by six.
// Input is held off from a closing item until its result is in the output
// register. A result waiting on a stalled receiver does not block new items;
// only the next closing item waits for the output register to empty.
// Configuration: csr byte address 0 holds gate, address 4 holds continuous.
// Reset clears the counters, peak, hold-off and baseline, sets gate to 100 and
// continuous to 0, and empties the output register.
`default_nettype none
module capacitive_touch_key_detector #(
   parameter int SCAN_SAMPLES      = ctkd_pkg::SCAN_SAMPLES_DEF,
   parameter int CONT_SCAN_SAMPLES = ctkd_pkg::CONT_SAMPLES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   ctkd_req_if.sink                               req_bus,
   ctkd_rsp_if.source                             rsp_bus,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [ctkd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [ctkd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output      logic [ctkd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output      logic                              csr_pready
);

   localparam int DW = ctkd_pkg::CSR_DATA_W;
   localparam int GW = ctkd_pkg::GATE_W;

   ctkd_pkg::ctkd_cmd_type    cmd;
   ctkd_pkg::ctkd_stat_type   stat;
   ctkd_pkg::ctkd_result_type result;

   logic [GW-1:0] gate_reg_ff, gate_reg_in;
   logic          cont_ff, cont_in;
   logic          csr_write;
   logic          csr_index;
   logic          in_fire;
   logic          out_free;

   logic                      rsp_valid_ff, rsp_valid_in;
   ctkd_pkg::ctkd_result_type rsp_data_ff, rsp_data_in;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      gate_reg_in = gate_reg_ff;
      cont_in     = cont_ff;
      if (csr_write) begin
         unique case (csr_index)
            ctkd_pkg::REG_GATE:       gate_reg_in = csr_pwdata[GW-1:0];
            ctkd_pkg::REG_CONTINUOUS: cont_in     = csr_pwdata[0];
            default:                  gate_reg_in = gate_reg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         ctkd_pkg::REG_GATE:       csr_prdata = DW'(gate_reg_ff);
         ctkd_pkg::REG_CONTINUOUS: csr_prdata = DW'(cont_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_reg_ff <= GW'(ctkd_pkg::GATE_RESET);
         cont_ff     <= 1'b0;
      end else begin
         gate_reg_ff <= gate_reg_in;
         cont_ff     <= cont_in;
      end
   end

   // handshakes
   assign req_bus.ready = cmd.in_ready;
   assign in_fire       = req_bus.valid && cmd.in_ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   ctkd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_fire  (in_fire),
      .in_mode  (req_bus.mode),
      .out_free (out_free),
      .stat     (stat),
      .cmd      (cmd)
   );

   ctkd_datapath #(
      .SCAN_SAMPLES      (SCAN_SAMPLES),
      .CONT_SCAN_SAMPLES (CONT_SCAN_SAMPLES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sample     (req_bus.charge_time),
      .gate       (gate_reg_ff),
      .continuous (cont_ff),
      .stat       (stat),
      .result     (result)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.result_kind = rsp_data_ff.result_kind;
   assign rsp_bus.touched     = rsp_data_ff.touched;
   assign rsp_bus.peak        = rsp_data_ff.peak;
   assign rsp_bus.baseline    = rsp_data_ff.baseline;

endmodule
`default_nettype wire
